// File: rtl/cpsat_pkg.sv
// Package for the convex polygon SAT collision block.
// Holds shared widths, queue entry type and engine state encoding. No dependencies.
`default_nettype none
package cpsat_pkg;
    localparam int MaxVerts   = 16;
    localparam int CoordBits  = 16;
    localparam int IdxBits    = $clog2(MaxVerts);
    localparam int CntBits    = $clog2(MaxVerts + 1);
    localparam int DiffBits   = CoordBits + 1;
    localparam int ProdBits   = CoordBits + DiffBits;
    localparam int DotBits    = ProdBits + 1;
    localparam int QDepth     = 2;

    // Work unit handed from the front end to the engine.
    typedef struct packed {
        logic [CntBits-1:0] cnt_a;
        logic [CntBits-1:0] cnt_b;
        logic               dropped;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE0,
        ST_EDGE1,
        ST_PROJ,
        ST_DRAIN,
        ST_CHECK,
        ST_DONE
    } eng_state_t;
endpackage
`default_nettype wire

// File: rtl/cpsat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module cpsat_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/cpsat_front.sv
// Front end: accepts vertex beats, writes them to the polygon stores and
// issues a job when last arrives. Depends on cpsat_pkg.
`default_nettype none
module cpsat_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic signed [cpsat_pkg::CoordBits-1:0] s_vertex_x,
    input  wire logic signed [cpsat_pkg::CoordBits-1:0] s_vertex_y,
    input  wire logic                          s_last,
    input  wire logic                          store_busy,
    output logic                               we_a,
    output logic                               we_b,
    output logic [cpsat_pkg::IdxBits-1:0]      waddr,
    output logic [2*cpsat_pkg::CoordBits-1:0]  wdata,
    output logic                               job_push,
    output cpsat_pkg::job_t                    job
);
    logic [cpsat_pkg::CntBits-1:0] cnt_a_reg, cnt_a_next;
    logic [cpsat_pkg::CntBits-1:0] cnt_b_reg, cnt_b_next;
    logic                          drop_reg, drop_next;
    logic                          acc, full_a, full_b, drop_now;

    // Stores are shared with the engine, so hold input while a job runs.
    assign s_ready = !store_busy;
    assign acc     = s_valid && s_ready;
    assign full_a  = cnt_a_reg == cpsat_pkg::CntBits'(cpsat_pkg::MaxVerts);
    assign full_b  = cnt_b_reg == cpsat_pkg::CntBits'(cpsat_pkg::MaxVerts);
    assign drop_now = s_mode ? full_b : full_a;

    assign we_a  = acc && !s_mode && !full_a;
    assign we_b  = acc && s_mode && !full_b;
    assign waddr = s_mode ? cnt_b_reg[cpsat_pkg::IdxBits-1:0]
                          : cnt_a_reg[cpsat_pkg::IdxBits-1:0];
    assign wdata = {s_vertex_x, s_vertex_y};

    always_comb begin
        cnt_a_next = cnt_a_reg + cpsat_pkg::CntBits'(we_a);
        cnt_b_next = cnt_b_reg + cpsat_pkg::CntBits'(we_b);
        drop_next  = drop_reg || (acc && drop_now);
        job_push   = acc && s_last;
        job.cnt_a  = cnt_a_next;
        job.cnt_b  = cnt_b_next;
        job.dropped = drop_next;
        if (job_push) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            drop_reg  <= drop_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/cpsat_queue.sv
// Short job queue between front end and engine.
// Depends on cpsat_pkg.
`default_nettype none
module cpsat_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire cpsat_pkg::job_t push_data,
    input  wire logic            pop,
    output logic                 not_empty,
    output logic                 not_full,
    output cpsat_pkg::job_t      head
);
    localparam int PtrBits = $clog2(cpsat_pkg::QDepth);
    cpsat_pkg::job_t      entry_reg [cpsat_pkg::QDepth];
    logic [PtrBits-1:0]   wp_reg, rp_reg;
    logic [PtrBits:0]     cnt_reg;

    assign not_empty = cnt_reg != '0;
    assign not_full  = cnt_reg != (PtrBits+1)'(cpsat_pkg::QDepth);
    assign head      = entry_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/cpsat_engine.sv
// SAT engine: walks the edge normals of A then B until one separates, projects
// all vertices one per cycle through one dot-product unit and tracks min/max. Depends on cpsat_pkg.
`default_nettype none
module cpsat_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          job_valid,
    input  wire cpsat_pkg::job_t               job,
    output logic                               job_pop,
    output logic                               busy,
    output logic [cpsat_pkg::IdxBits-1:0]      raddr,
    input  wire logic [2*cpsat_pkg::CoordBits-1:0] rdata_a,
    input  wire logic [2*cpsat_pkg::CoordBits-1:0] rdata_b,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic                               m_overflow
);
    localparam int CB = cpsat_pkg::CoordBits;
    localparam int DB = cpsat_pkg::DotBits;
    localparam int CN = cpsat_pkg::CntBits;

    cpsat_pkg::eng_state_t st_reg, st_next;
    cpsat_pkg::job_t       job_reg, job_next;
    logic            epoly_reg, epoly_next;   // polygon whose edges are walked
    logic [CN-1:0]   eidx_reg, eidx_next;
    logic [CN-1:0]   pidx_reg, pidx_next;     // projection vertex, A then B
    logic            ppoly_reg, ppoly_next;
    logic signed [CB-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [CB:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic            rv_reg, rv_next, rvb_reg, rvb_next;    // read in flight
    logic            pv_reg, pvb_reg;                       // product valid
    logic            first_a_reg, first_b_reg, fa_next, fb_next;
    logic signed [DB-2:0] px_reg, py_reg;
    logic signed [DB-1:0] amin_reg, amax_reg, bmin_reg, bmax_reg;
    logic            sep_reg, sep_next;
    logic            mv_reg, mv_next, hit_reg, hit_next, ovf_reg, ovf_next;
    logic [CN-1:0]   ecnt, enext;
    logic [2*CB-1:0] rd;
    logic signed [CB-1:0] rx, ry;
    logic signed [DB-1:0] dot;
    logic            clr;

    assign busy       = st_reg != cpsat_pkg::ST_IDLE || job_valid;
    assign m_valid    = mv_reg;
    assign m_hit      = hit_reg;
    assign m_overflow = ovf_reg;
    assign rd  = rvb_reg ? rdata_b : rdata_a;
    assign rx  = rd[2*CB-1:CB];
    assign ry  = rd[CB-1:0];
    assign dot = DB'(px_reg) + DB'(py_reg);
    assign ecnt  = epoly_reg ? job_reg.cnt_b : job_reg.cnt_a;
    assign enext = (eidx_reg + 1'b1 == ecnt) ? '0 : eidx_reg + 1'b1;

    always_comb begin
        st_next = st_reg; job_next = job_reg; epoly_next = epoly_reg;
        eidx_next = eidx_reg; pidx_next = pidx_reg; ppoly_next = ppoly_reg;
        x0_next = x0_reg; y0_next = y0_reg; nx_next = nx_reg; ny_next = ny_reg;
        rv_next = 1'b0; rvb_next = ppoly_reg;
        sep_next = sep_reg; mv_next = mv_reg; hit_next = hit_reg; ovf_next = ovf_reg;
        job_pop = 1'b0; raddr = '0; clr = 1'b0;
        fa_next = first_a_reg; fb_next = first_b_reg;
        if (m_ready) mv_next = 1'b0;
        unique case (st_reg)
            cpsat_pkg::ST_IDLE: begin
                if (job_valid && !mv_reg) begin
                    job_pop = 1'b1; job_next = job; epoly_next = 1'b0;
                    eidx_next = '0; sep_next = 1'b0;
                    if (job.cnt_a == '0 || job.cnt_b == '0) begin
                        st_next = cpsat_pkg::ST_DONE;
                    end else begin
                        st_next = cpsat_pkg::ST_EDGE0;
                    end
                end
            end
            cpsat_pkg::ST_EDGE0: begin
                // fetch edge start
                raddr = eidx_reg[cpsat_pkg::IdxBits-1:0];
                rvb_next = epoly_reg;
                st_next = cpsat_pkg::ST_EDGE1;
            end
            cpsat_pkg::ST_EDGE1: begin
                // latch start, fetch edge end
                x0_next = rx; y0_next = ry;
                raddr = enext[cpsat_pkg::IdxBits-1:0];
                rvb_next = epoly_reg;
                pidx_next = '0; ppoly_next = 1'b0;
                st_next = cpsat_pkg::ST_PROJ;
            end
            cpsat_pkg::ST_PROJ: begin
                if (pidx_reg == '0 && !ppoly_reg) begin
                    // normal = (dy, -dx)
                    ny_next = (CB+1)'(x0_reg) - (CB+1)'(rx);
                    nx_next = (CB+1)'(ry) - (CB+1)'(y0_reg);
                    clr = 1'b1;
                end
                raddr = pidx_reg[cpsat_pkg::IdxBits-1:0];
                rv_next = 1'b1; rvb_next = ppoly_reg;
                if (!ppoly_reg && pidx_reg + 1'b1 == job_reg.cnt_a) begin
                    ppoly_next = 1'b1; pidx_next = '0;
                end else if (ppoly_reg && pidx_reg + 1'b1 == job_reg.cnt_b) begin
                    st_next = cpsat_pkg::ST_DRAIN;
                end else begin
                    pidx_next = pidx_reg + 1'b1;
                end
            end
            cpsat_pkg::ST_DRAIN: begin
                if (!rv_reg && !pv_reg) st_next = cpsat_pkg::ST_CHECK;
            end
            cpsat_pkg::ST_CHECK: begin
                if (amax_reg < bmin_reg || bmax_reg < amin_reg) sep_next = 1'b1;
                if (enext == '0) begin
                    if (epoly_reg) st_next = cpsat_pkg::ST_DONE;
                    else begin
                        epoly_next = 1'b1; eidx_next = '0;
                        st_next = cpsat_pkg::ST_EDGE0;
                    end
                end else begin
                    eidx_next = enext; st_next = cpsat_pkg::ST_EDGE0;
                end
                if (amax_reg < bmin_reg || bmax_reg < amin_reg) st_next = cpsat_pkg::ST_DONE;
            end
            cpsat_pkg::ST_DONE: begin
                if (!mv_reg) begin
                    mv_next = 1'b1; ovf_next = job_reg.dropped;
                    hit_next = job_reg.cnt_a != '0 && job_reg.cnt_b != '0 && !sep_reg;
                    st_next = cpsat_pkg::ST_IDLE;
                end
            end
            default: st_next = cpsat_pkg::ST_IDLE;
        endcase
        if (clr) begin
            fa_next = 1'b1; fb_next = 1'b1;
        end else if (pv_reg) begin
            if (pvb_reg) fb_next = 1'b0; else fa_next = 1'b0;
        end
    end

    // Projection pipeline: read -> multiply -> sum/track.
    always_ff @(posedge aclk) begin
        px_reg <= (DB-1)'(rx * nx_reg);
        py_reg <= (DB-1)'(ry * ny_reg);
        if (pv_reg) begin
            if (!pvb_reg) begin
                if (first_a_reg || dot < amin_reg) amin_reg <= dot;
                if (first_a_reg || dot > amax_reg) amax_reg <= dot;
            end else begin
                if (first_b_reg || dot < bmin_reg) bmin_reg <= dot;
                if (first_b_reg || dot > bmax_reg) bmax_reg <= dot;
            end
        end
        job_reg <= job_next; epoly_reg <= epoly_next; eidx_reg <= eidx_next;
        pidx_reg <= pidx_next; ppoly_reg <= ppoly_next; x0_reg <= x0_next;
        y0_reg <= y0_next; nx_reg <= nx_next; ny_reg <= ny_next;
        rvb_reg <= rvb_next; pvb_reg <= rvb_reg; sep_reg <= sep_next;
        hit_reg <= hit_next; ovf_reg <= ovf_next;
        first_a_reg <= fa_next; first_b_reg <= fb_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= cpsat_pkg::ST_IDLE;
            rv_reg <= 1'b0; pv_reg <= 1'b0; mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next; rv_reg <= rv_next; pv_reg <= rv_reg; mv_reg <= mv_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/convex_polygon_sat_collision.sv
// Convex polygon collision by the separating axis theorem, top level.
// Depends on cpsat_pkg, cpsat_front, cpsat_queue, cpsat_engine, cpsat_ram.
//
// Input channel (s_*): one beat per vertex. s_mode picks polygon A (0) or
// B (1); coordinates are signed Q12.4. Up to 16 vertices per polygon are
// kept; extra vertices are dropped and reported through m_overflow.
// A beat with s_last set closes the pair of polygons and starts the test.
// Result channel (m_*): one beat per closing vertex, m_hit set when no
// edge normal of either polygon separates them and neither polygon is empty.
// m_valid rises once the test ends, sooner when an axis separates early;
// each test runs on one shared projection unit fed by one read port per
// store, one vertex per cycle.
// Throughput: vertex beats are taken one per cycle while no test runs;
// s_ready drops from the closing beat until the engine frees the stores.
// Reset clears vertex counts, the drop flag, the queue and the result
// valid flag; store contents stay undefined. When the receiver stalls, the
// result holds in its register and the next test waits to start.
`default_nettype none
module convex_polygon_sat_collision (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic signed [cpsat_pkg::CoordBits-1:0] s_vertex_x,
    input  wire logic signed [cpsat_pkg::CoordBits-1:0] s_vertex_y,
    input  wire logic                          s_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic                               m_overflow
);
    logic                               we_a, we_b, push, pop, q_ne, q_nf;
    logic                               eng_busy, store_busy;
    logic [cpsat_pkg::IdxBits-1:0]      waddr, raddr;
    logic [2*cpsat_pkg::CoordBits-1:0]  wdata, rdata_a, rdata_b;
    cpsat_pkg::job_t                    job_in, job_head;

    // Hold the front end while a job is queued or running (stores shared).
    assign store_busy = eng_busy || q_ne || !q_nf;

    cpsat_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_vertex_x,
        .s_vertex_y, .s_last, .store_busy, .we_a, .we_b, .waddr, .wdata,
        .job_push(push), .job(job_in)
    );

    cpsat_queue u_queue (
        .aclk, .aresetn, .push, .push_data(job_in), .pop,
        .not_empty(q_ne), .not_full(q_nf), .head(job_head)
    );

    cpsat_ram #(.Width(2*cpsat_pkg::CoordBits), .Depth(cpsat_pkg::MaxVerts)) u_ram_a (
        .aclk, .we(we_a), .waddr, .wdata, .raddr, .rdata(rdata_a)
    );

    cpsat_ram #(.Width(2*cpsat_pkg::CoordBits), .Depth(cpsat_pkg::MaxVerts)) u_ram_b (
        .aclk, .we(we_b), .waddr, .wdata, .raddr, .rdata(rdata_b)
    );

    cpsat_engine u_engine (
        .aclk, .aresetn, .job_valid(q_ne), .job(job_head), .job_pop(pop),
        .busy(eng_busy), .raddr, .rdata_a, .rdata_b,
        .m_valid, .m_ready, .m_hit, .m_overflow
    );
endmodule
`default_nettype wire
